FILE: rtl/core/pto_pkg.sv
`timescale 1ns / 1ps
// pto_pkg: shared constants, command codes and the result struct for the
// priority topological order block. No dependencies.
package pto_pkg;

    // default sizes handed to the top level
    localparam int DEF_MAX_JOBS      = 32;
    localparam int DEF_PRIORITY_BITS = 16;

    // fixed field widths of the stream items
    localparam int JOB_W       = 5;
    localparam int MASK_W      = 32;
    localparam int PRIO_IN_W   = 16;
    localparam int CNT_W       = 6;
    localparam int TDATA_IN_W  = 56;
    localparam int TDATA_OUT_W = 8;

    // widest run: one successor bit per job
    localparam int MASK_JOBS = 32;

    localparam logic [CNT_W-1:0] CNT_RESET = 6'd32;

    // command codes carried in the input tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // one placed job handed from the scan engine to the output register
    typedef struct packed {
        logic [JOB_W-1:0] job;
        logic             last;
        logic             stuck;
    } t_result;

endpackage

FILE: rtl/core/pto_ram.sv
`timescale 1ns / 1ps
// pto_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
module pto_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/pto_sched.sv
`timescale 1ns / 1ps
// pto_sched: scan engine that walks the job table memory to build the order.
// Depends on pto_pkg for field widths and the result struct.
module pto_sched #(
    parameter int MAX_JOBS      = pto_pkg::DEF_MAX_JOBS,
    parameter int PRIORITY_BITS = pto_pkg::DEF_PRIORITY_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_run,
    input  logic [pto_pkg::CNT_W-1:0]               i_job_count,
    output logic                                    o_idle,
    output logic                                    o_rd_en,
    output logic [$clog2(MAX_JOBS)-1:0]             o_rd_addr,
    input  logic [pto_pkg::MASK_W+PRIORITY_BITS-1:0] i_rd_data,
    output logic                                    o_res_vld,
    output pto_pkg::t_result                        o_res,
    input  logic                                    i_res_rdy
);

    localparam int AW = $clog2(MAX_JOBS);
    localparam int RL = (MAX_JOBS < pto_pkg::MASK_JOBS) ? MAX_JOBS : pto_pkg::MASK_JOBS;
    localparam int NW = $clog2(RL + 1);
    localparam int SW = $clog2(RL);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_BLOCK,
        S_PICK,
        S_EMIT
    } t_state;

    t_state                           r_state;
    logic [NW-1:0]                    r_n;
    logic [SW-1:0]                    r_last_idx;
    logic [NW-1:0]                    r_idx;
    logic                             r_rd_vld;
    logic [SW-1:0]                    r_rd_p;
    logic [RL-1:0]                    r_sched;
    logic [RL-1:0]                    r_blocked;
    logic [NW-1:0]                    r_placed;
    logic                             r_found;
    logic [SW-1:0]                    r_best;
    logic signed [PRIORITY_BITS-1:0]  r_best_prio;

    logic                             w_issue;
    logic [pto_pkg::MASK_W-1:0]       w_succ;
    logic signed [PRIORITY_BITS-1:0]  w_prio;
    logic                             w_cand;
    logic                             w_better;
    logic                             w_rd_last;
    logic                             w_fire;
    logic [NW-1:0]                    w_n;
    logic [NW-1:0]                    w_next_placed;

    // clamp the job count to one job up to the widest run
    always_comb begin
        if (i_job_count == '0) begin
            w_n = NW'(1);
        end else if (i_job_count > pto_pkg::CNT_W'(RL)) begin
            w_n = NW'(RL);
        end else begin
            w_n = NW'(i_job_count);
        end
    end

    // one table read per cycle while a scan pass is running
    assign w_issue   = ((r_state == S_BLOCK) || (r_state == S_PICK)) && (r_idx < r_n);
    assign o_rd_en   = w_issue;
    assign o_rd_addr = AW'(r_idx);

    // returned entry: successor bits low, priority above
    assign w_succ    = i_rd_data[pto_pkg::MASK_W-1:0];
    assign w_prio    = $signed(i_rd_data[pto_pkg::MASK_W +: PRIORITY_BITS]);
    assign w_cand    = r_rd_vld && !r_sched[r_rd_p] && !r_blocked[r_rd_p];
    assign w_better  = !r_found || (w_prio > r_best_prio);
    assign w_rd_last = r_rd_vld && (r_rd_p == r_last_idx);

    assign w_next_placed = r_placed + NW'(1);

    // result offered to the output register
    assign o_idle    = (r_state == S_IDLE);
    assign o_res_vld = (r_state == S_FIRST) || (r_state == S_EMIT);
    assign w_fire    = o_res_vld && i_res_rdy;

    always_comb begin
        o_res.job   = '0;
        o_res.last  = 1'b0;
        o_res.stuck = 1'b0;
        if (r_state == S_FIRST) begin
            o_res.last = (r_n == NW'(1));
        end else if (!r_found) begin
            o_res.last  = 1'b1;
            o_res.stuck = 1'b1;
        end else begin
            o_res.job  = pto_pkg::JOB_W'(r_best);
            o_res.last = (w_next_placed == r_n);
        end
    end

    // sequencer: start job, then blocked-mask pass and pick pass per job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            r_rd_p   <= SW'(r_idx);
            if (w_issue) begin
                r_idx <= r_idx + NW'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_run) begin
                        r_n        <= w_n;
                        r_last_idx <= SW'(w_n - NW'(1));
                        r_sched    <= RL'(1);
                        r_placed   <= NW'(1);
                        r_state    <= S_FIRST;
                    end
                end
                S_FIRST: begin
                    if (w_fire) begin
                        r_idx     <= '0;
                        r_blocked <= '0;
                        r_state   <= (r_n == NW'(1)) ? S_IDLE : S_BLOCK;
                    end
                end
                S_BLOCK: begin
                    // every unscheduled job blocks its successors
                    if (r_rd_vld && !r_sched[r_rd_p]) begin
                        r_blocked <= r_blocked | w_succ[RL-1:0];
                    end
                    if (w_rd_last) begin
                        r_idx   <= NW'(1);
                        r_found <= 1'b0;
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    // highest priority wins, earlier index keeps ties
                    if (w_cand && w_better) begin
                        r_best      <= r_rd_p;
                        r_best_prio <= w_prio;
                        r_found     <= 1'b1;
                    end
                    if (w_rd_last) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_fire) begin
                        r_sched   <= r_sched | (RL'(1) << r_best);
                        r_placed  <= w_next_placed;
                        r_idx     <= '0;
                        r_blocked <= '0;
                        if (!r_found || (w_next_placed == r_n)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_BLOCK;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/priority_topological_order.sv
`timescale 1ns / 1ps
// priority_topological_order: top level with the job table memory, the
// job count register and the output register. Uses pto_pkg, pto_ram, pto_sched.
//
// Usage:
//   Input channel s_*: tuser is the command (load or run), tdata carries the
//   job index, successor mask and signed priority. A load item writes one
//   job entry into the table memory and gives no result; loads are taken
//   one per cycle. A run item orders jobs 0 to n-1, n being the job count
//   register clamped to 1..min(MAX_JOBS, 32).
//   Output channel m_*: one item per placed job, start job first; tlast
//   marks the final item of a run, tuser marks a stuck run (a cycle), which
//   ends with job 0.
//   Picks: each pick is a blocked-mask pass and a priority pass over the
//   table memory's single read port. No input item is taken while a run
//   is in progress.
//   The job count is written through i_cfg_we / i_cfg_wdata between runs.
//   Reset clears the engine and output valid and sets the job count to 32;
//   table contents stay undefined until loaded.
//   When the receiver stalls, the result waits in the output register and
//   the engine holds its next result until the register frees up.
module priority_topological_order #(
    parameter int MAX_JOBS      = pto_pkg::DEF_MAX_JOBS,
    parameter int PRIORITY_BITS = pto_pkg::DEF_PRIORITY_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pto_pkg::CNT_W-1:0]        i_cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // job_index [4:0], successor_mask [36:5], priority_req [52:37], zero pad
    input  logic [pto_pkg::TDATA_IN_W-1:0]   s_tdata,
    // command [0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // chosen_job [4:0], zero pad
    output logic [pto_pkg::TDATA_OUT_W-1:0]  m_tdata,
    output logic                             m_tlast,
    // stuck [0]
    output logic                             m_tuser
);

    localparam int AW    = $clog2(MAX_JOBS);
    localparam int PB_IN = (PRIORITY_BITS < pto_pkg::PRIO_IN_W) ?
                           PRIORITY_BITS : pto_pkg::PRIO_IN_W;
    localparam int RAM_W = pto_pkg::MASK_W + PRIORITY_BITS;

    logic [pto_pkg::CNT_W-1:0]     r_job_count;
    logic                          r_m_valid;
    pto_pkg::t_result              r_m_res;

    logic [pto_pkg::JOB_W-1:0]     w_job_idx;
    logic [pto_pkg::MASK_W-1:0]    w_succ_in;
    logic [pto_pkg::PRIO_IN_W-1:0] w_prio_in;
    logic [PRIORITY_BITS-1:0]      w_prio_st;
    logic                          w_accept;
    logic                          w_load;
    logic                          w_run;
    logic                          w_idle;
    logic                          w_rd_en;
    logic [AW-1:0]                 w_rd_addr;
    logic [RAM_W-1:0]              w_rd_data;
    logic                          w_res_vld;
    logic                          w_res_rdy;
    pto_pkg::t_result              w_res;

    // input item decode
    assign w_job_idx = s_tdata[pto_pkg::JOB_W-1:0];
    assign w_succ_in = s_tdata[pto_pkg::JOB_W +: pto_pkg::MASK_W];
    assign w_prio_in = s_tdata[pto_pkg::JOB_W + pto_pkg::MASK_W +: pto_pkg::PRIO_IN_W];
    assign w_prio_st = PRIORITY_BITS'($signed(w_prio_in[PB_IN-1:0]));

    assign s_tready = w_idle;
    assign w_accept = s_tvalid && s_tready;
    assign w_load   = w_accept && (s_tuser == pto_pkg::CMD_LOAD) &&
                      (32'(w_job_idx) < MAX_JOBS);
    assign w_run    = w_accept && (s_tuser == pto_pkg::CMD_RUN);

    // job count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_count <= pto_pkg::CNT_RESET;
        end else if (i_cfg_we) begin
            r_job_count <= i_cfg_wdata;
        end
    end

    // job table: loads only while idle, reads only during a run
    pto_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_JOBS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (AW'(w_job_idx)),
        .i_wdata ({w_prio_st, w_succ_in}),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    // scan engine
    pto_sched #(
        .MAX_JOBS      (MAX_JOBS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run       (w_run),
        .i_job_count (r_job_count),
        .o_idle      (w_idle),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_res_vld   (w_res_vld),
        .o_res       (w_res),
        .i_res_rdy   (w_res_rdy)
    );

    // output register
    assign w_res_rdy = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_vld && w_res_rdy) begin
            r_m_valid <= 1'b1;
            r_m_res   <= w_res;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = pto_pkg::TDATA_OUT_W'(r_m_res.job);
    assign m_tlast  = r_m_res.last;
    assign m_tuser  = r_m_res.stuck;

    // engine takes no input item while it still has a result to give
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !w_res_vld)
        else $error("input ready while a result is pending");

    // a blocked result holds until the output register frees up
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_vld && !w_res_rdy) |=> (w_res_vld && $stable(w_res)))
        else $error("pending result changed while stalled");

    // a stuck item always ends the run and names the start job
    a_stuck_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("stuck item without last or with nonzero job");

endmodule
